@@ hw/rtl/sparse_row_accumulator_macros.svh @@
// ----------------------------------------------------------------------------
// Sparse row accumulator assertion macros
// Concurrent assertion shorthands clocked by clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SPARSE_ROW_ACCUMULATOR_MACROS_SVH
`define SPARSE_ROW_ACCUMULATOR_MACROS_SVH

`ifndef SYNTHESIS
`define SRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SRA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SRA_ASSERT_IMP(lbl, ante, cons, msg)
`define SRA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/sra_pkg.sv @@
// ----------------------------------------------------------------------------
// Sparse row accumulator package
// Widths, state codes, slot entry type and saturating addition.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sra_pkg;

  localparam int COLUMNS = 64;
  localparam int SLOT_W  = $clog2(COLUMNS);
  localparam int CNT_W   = $clog2(COLUMNS + 1);
  localparam int COL_W   = 6;
  localparam int VAL_W   = 32;
  localparam int SUM_W   = 64;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_FLUSH,
    ST_EMPTY
  } sra_state_t;

  typedef struct packed {
    logic [COL_W-1:0]        column;
    logic signed [SUM_W-1:0] sum;
  } slot_entry_t;

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [SUM_W-1:0] b);
    logic signed [SUM_W-1:0] s;
    s = a + b;
    if ((a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1])) begin
      return a[SUM_W-1] ? SUM_MIN : SUM_MAX;
    end
    return s;
  endfunction

endpackage

@@ hw/rtl/sra_if.sv @@
// ----------------------------------------------------------------------------
// Sparse row accumulator channels
// Valid/ready channels for product terms and for accumulated results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sra_in_if;
  import sra_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [COL_W-1:0]        column;
  logic signed [VAL_W-1:0] a_value;
  logic signed [VAL_W-1:0] b_value;
  logic                    has_term;
  logic                    row_end;

  modport source (output valid, output column, output a_value, output b_value,
                  output has_term, output row_end, input ready);
  modport sink (input valid, input column, input a_value, input b_value,
                input has_term, input row_end, output ready);
endinterface

interface sra_out_if;
  import sra_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [COL_W-1:0]        out_column;
  logic signed [SUM_W-1:0] sum_value;
  logic                    last;
  logic                    row_empty;

  modport source (output valid, output out_column, output sum_value, output last,
                  output row_empty, input ready);
  modport sink (input valid, input out_column, input sum_value, input last,
                input row_empty, output ready);
endinterface

@@ hw/rtl/sparse_row_accumulator.sv @@
// ----------------------------------------------------------------------------
// Sparse row accumulator
// Product terms are accepted one per cycle while the input is open and
// accumulate in two stages. A row end closes the input until the row's
// results are out, one per cycle while the receiver is ready. An empty row
// gives one empty result. Synchronous reset clears all column flags at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sparse_row_accumulator_macros.svh"

module sparse_row_accumulator (
  input  logic            clk,
  input  logic            rst,
  sra_in_if.sink          in_item,
  sra_out_if.source       out_item
);
  import sra_pkg::*;

  sra_state_t state, state_next;

  logic in_ready, accept, flush_busy, load_empty, out_free;

  logic [COLUMNS-1:0] slot_vld;
  logic [SLOT_W-1:0]  slot_map [COLUMNS];
  slot_entry_t        slot_mem [COLUMNS];
  logic [CNT_W-1:0]   count;

  logic signed [SUM_W-1:0] prod_in;

  logic                    p1_vld, p1_term;
  logic [COL_W-1:0]        p1_col;
  logic signed [SUM_W-1:0] p1_prod;
  logic [SLOT_W-1:0]       map_q, mfwd_slot;
  logic                    mfwd_hit;
  logic                    s1_open;
  logic [SLOT_W-1:0]       s1_slot;

  logic                    p2_vld, p2_term, p2_open;
  logic [SLOT_W-1:0]       p2_slot;
  logic [COL_W-1:0]        p2_col;
  logic signed [SUM_W-1:0] p2_prod;
  slot_entry_t             sum_q;
  logic                    sfwd_hit;
  logic signed [SUM_W-1:0] sfwd_val, s2_old, s2_new;
  logic                    s2_wr;

  logic                    rd_en, flush_rd, move, flush_done, rd_pend, rd_last;
  logic [SLOT_W-1:0]       rd_addr;
  logic [CNT_W-1:0]        rd_idx;

  logic                    out_vld, out_last, out_empty;
  logic [COL_W-1:0]        out_col;
  logic signed [SUM_W-1:0] out_sum;

  assign accept  = in_item.valid && in_ready;
  assign prod_in = SUM_W'(in_item.a_value) * SUM_W'(in_item.b_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (accept && in_item.row_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p1_vld && !p2_vld) begin
          state_next = (count == '0) ? ST_EMPTY : ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (flush_done) begin
          state_next = ST_RUN;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    flush_busy = 1'b0;
    load_empty = 1'b0;
    unique case (state)
      ST_RUN:   in_ready = 1'b1;
      ST_DRAIN: in_ready = 1'b0;
      ST_FLUSH: flush_busy = 1'b1;
      ST_EMPTY: load_empty = out_free;
      default:  in_ready = 1'b0;
    endcase
  end

  // Stage one: product register and column map lookup.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else begin
      p1_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_term   <= in_item.has_term;
      p1_col    <= in_item.column;
      p1_prod   <= prod_in;
      mfwd_hit  <= p1_vld && s1_open && (p1_col == in_item.column);
      mfwd_slot <= s1_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      map_q <= slot_map[in_item.column];
    end
    if (p1_vld && s1_open) begin
      slot_map[p1_col] <= count[SLOT_W-1:0];
    end
  end

  assign s1_open = p1_term && !slot_vld[p1_col];
  assign s1_slot = s1_open ? count[SLOT_W-1:0] : (mfwd_hit ? mfwd_slot : map_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
      count    <= '0;
    end else if (flush_done) begin
      slot_vld <= '0;
      count    <= '0;
    end else if (p1_vld && s1_open) begin
      slot_vld[p1_col] <= 1'b1;
      count            <= count + 1'b1;
    end
  end

  // Stage two: slot read, saturating accumulate and write back.
  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else begin
      p2_vld <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    p2_term <= p1_term;
    p2_open <= s1_open;
    p2_slot <= s1_slot;
    p2_col  <= p1_col;
    p2_prod <= p1_prod;
  end

  assign rd_en   = p1_vld || flush_rd;
  assign rd_addr = p1_vld ? s1_slot : rd_idx[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      sum_q    <= slot_mem[rd_addr];
      sfwd_hit <= s2_wr && (p2_slot == rd_addr);
      sfwd_val <= s2_new;
    end
    if (s2_wr) begin
      slot_mem[p2_slot] <= '{column: p2_col, sum: s2_new};
    end
  end

  assign s2_old = sfwd_hit ? sfwd_val : sum_q.sum;
  assign s2_new = p2_open ? p2_prod : sat_add(s2_old, p2_prod);
  assign s2_wr  = p2_vld && p2_term;

  // Row flush walks the open slots in order of first appearance.
  assign out_free   = !out_vld || out_item.ready;
  assign move       = rd_pend && out_free;
  assign flush_rd   = flush_busy && (rd_idx < count) && (!rd_pend || move);
  assign flush_done = flush_busy && (rd_idx == count) && !rd_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else if (flush_rd) begin
      rd_pend <= 1'b1;
    end else if (move) begin
      rd_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DRAIN) begin
      rd_idx <= '0;
    end else if (flush_rd) begin
      rd_idx  <= rd_idx + 1'b1;
      rd_last <= (CNT_W'(rd_idx + 1'b1) == count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (move || load_empty) begin
      out_vld <= 1'b1;
    end else if (out_item.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_col   <= sum_q.column;
      out_sum   <= sum_q.sum;
      out_last  <= rd_last;
      out_empty <= 1'b0;
    end else if (load_empty) begin
      out_col   <= '0;
      out_sum   <= '0;
      out_last  <= 1'b1;
      out_empty <= 1'b1;
    end
  end

  assign in_item.ready       = in_ready;
  assign out_item.valid      = out_vld;
  assign out_item.out_column = out_col;
  assign out_item.sum_value  = out_sum;
  assign out_item.last       = out_last;
  assign out_item.row_empty  = out_empty;

  `SRA_ASSERT_IMP(a_count_range, 1'b1, count <= CNT_W'(COLUMNS), "open slot count overflow")
  `SRA_ASSERT_NXT(a_open_counts, p1_vld && s1_open, count == $past(count) + 1'b1, "slot open lost")
  `SRA_ASSERT_NXT(a_row_end_stall, accept && in_item.row_end, !in_item.ready, "input open after row end")
  `SRA_ASSERT_IMP(a_empty_form, out_vld && out_empty, out_last && (out_sum == '0), "bad empty result")

endmodule

@@ dv/sparse_row_accumulator_tb.sv @@
// ----------------------------------------------------------------------------
// Sparse row accumulator testbench
// Streams product terms and row ends into the accumulator under random
// sender bursts and receiver stalls, including one long receiver hold-off
// and two sender pauses until all results are back. An internal predictor
// tracks the open slots and saturating sums of the current row and checks
// every result transfer field by field against the oldest pending entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_row_accumulator_tb;
  import sra_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_TRIGGER = 30;
  localparam int RANDOM_ITEMS = 85;

  typedef struct {
    logic [COL_W-1:0]        column;
    logic signed [VAL_W-1:0] a_value;
    logic signed [VAL_W-1:0] b_value;
    logic                    has_term;
    logic                    row_end;
    logic                    wait_drain;
  } term_item_t;

  typedef struct {
    logic [COL_W-1:0]        column;
    logic signed [SUM_W-1:0] sum;
    logic                    last;
    logic                    empty;
  } row_entry_t;

  logic clk;
  logic rst;

  sra_in_if  in_ch ();
  sra_out_if out_ch ();

  sparse_row_accumulator dut (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  term_item_t term_queue[$];
  row_entry_t expected_entries[$];

  logic                    col_open [COLUMNS] = '{default: 1'b0};
  int                      col_slot [COLUMNS];
  logic [COL_W-1:0]        slot_col [COLUMNS];
  logic signed [SUM_W-1:0] slot_sum [COLUMNS];
  int                      open_count = 0;

  term_item_t cur_item;
  logic       offering;
  int         gap_left;
  int         burst_left;
  int         inputs_taken = 0;
  int         error_count = 0;
  int         cycle_count = 0;
  logic       hold_active;
  logic       pause_pending;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic signed [SUM_W-1:0] clamp_add(input logic signed [SUM_W-1:0] x,
                                                        input logic signed [SUM_W-1:0] y);
    logic signed [SUM_W:0] wide;
    wide = (SUM_W+1)'(x) + (SUM_W+1)'(y);
    if (wide[SUM_W] != wide[SUM_W-1]) begin
      return wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return wide[SUM_W-1:0];
  endfunction

  task automatic accumulate_term(input term_item_t it);
    logic signed [SUM_W-1:0] a_wide;
    logic signed [SUM_W-1:0] b_wide;
    logic signed [SUM_W-1:0] product;
    row_entry_t entry;
    if (it.has_term && it.column < COLUMNS) begin
      a_wide = SUM_W'(it.a_value);
      b_wide = SUM_W'(it.b_value);
      product = a_wide * b_wide;
      if (!col_open[it.column]) begin
        if (open_count < COLUMNS) begin
          col_open[it.column] = 1'b1;
          col_slot[it.column] = open_count;
          slot_col[open_count] = it.column;
          slot_sum[open_count] = product;
          open_count++;
        end
      end else begin
        slot_sum[col_slot[it.column]] = clamp_add(slot_sum[col_slot[it.column]], product);
      end
    end
    if (it.row_end) begin
      if (open_count == 0) begin
        entry.column = '0;
        entry.sum = '0;
        entry.last = 1'b1;
        entry.empty = 1'b1;
        expected_entries.push_back(entry);
      end else begin
        for (int k = 0; k < open_count; k++) begin
          entry.column = slot_col[k];
          entry.sum = slot_sum[k];
          entry.last = (k == open_count - 1);
          entry.empty = 1'b0;
          expected_entries.push_back(entry);
          col_open[slot_col[k]] = 1'b0;
        end
        open_count = 0;
      end
    end
    inputs_taken++;
  endtask

  function automatic logic [VAL_W-1:0] random_factor();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          3: return 32'hffff_ffff;
          default: return 32'h0001_0000;
        endcase
      end
      1: return $urandom_range(0, 1) ? 32'($urandom_range(0, 262143))
                                     : -32'($urandom_range(0, 262143));
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_term(input logic [COL_W-1:0] column, input logic [VAL_W-1:0] a_value,
                            input logic [VAL_W-1:0] b_value, input logic has_term,
                            input logic row_end);
    term_item_t it;
    it.column = column;
    it.a_value = a_value;
    it.b_value = b_value;
    it.has_term = has_term;
    it.row_end = row_end;
    it.wait_drain = pause_pending;
    pause_pending = 1'b0;
    term_queue.push_back(it);
  endtask

  task automatic queue_noise();
    queue_term(6'($urandom), $urandom, $urandom, 1'b0, 1'b0);
  endtask

  task automatic queue_bare_end();
    queue_term(6'($urandom), $urandom, $urandom, 1'b0, 1'b1);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      offering = 1'b0;
      gap_left = 0;
      burst_left = 0;
      in_ch.valid    <= 1'b0;
      in_ch.column   <= '0;
      in_ch.a_value  <= '0;
      in_ch.b_value  <= '0;
      in_ch.has_term <= 1'b0;
      in_ch.row_end  <= 1'b0;
    end else begin
      if (offering && in_ch.ready) begin
        accumulate_term(cur_item);
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0 && !hold_active) begin
          gap_left--;
        end else if (term_queue.size() > 0 &&
                     !(term_queue[0].wait_drain && expected_entries.size() > 0)) begin
          cur_item = term_queue.pop_front();
          offering = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
          end
          burst_left--;
          if (burst_left == 0) begin
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_ch.valid <= offering;
      if (offering) begin
        in_ch.column   <= cur_item.column;
        in_ch.a_value  <= cur_item.a_value;
        in_ch.b_value  <= cur_item.b_value;
        in_ch.has_term <= cur_item.has_term;
        in_ch.row_end  <= cur_item.row_end;
      end
    end
  end

  int   hold_left;
  logic hold_done;
  int   ready_mode;
  int   mode_left;
  int   stall_phase;
  logic ready_next;

  always @(posedge clk) begin
    row_entry_t want;
    if (rst) begin
      hold_left = 0;
      hold_done = 1'b0;
      mode_left = 0;
      ready_mode = 0;
      stall_phase = 0;
      out_ch.ready <= 1'b0;
      hold_active <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_entries.size() == 0) begin
          report_mismatch($sformatf("unexpected result column=%0d sum=%h",
                                    out_ch.out_column, out_ch.sum_value));
        end else begin
          want = expected_entries.pop_front();
          if (out_ch.out_column !== want.column) begin
            report_mismatch($sformatf("out_column got %0d want %0d",
                                      out_ch.out_column, want.column));
          end
          if (out_ch.sum_value !== want.sum) begin
            report_mismatch($sformatf("sum_value got %h want %h",
                                      out_ch.sum_value, want.sum));
          end
          if (out_ch.last !== want.last) begin
            report_mismatch($sformatf("last got %b want %b", out_ch.last, want.last));
          end
          if (out_ch.row_empty !== want.empty) begin
            report_mismatch($sformatf("row_empty got %b want %b",
                                      out_ch.row_empty, want.empty));
          end
        end
      end
      stall_phase = (stall_phase + 1) % 5;
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (!hold_done && inputs_taken >= HOLD_TRIGGER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        ready_next = 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 80);
        end
        mode_left--;
        case (ready_mode)
          0: ready_next = 1'b1;
          1: ready_next = 1'($urandom_range(0, 1));
          2: ready_next = $urandom_range(0, 3) == 0;
          default: ready_next = stall_phase != 0;
        endcase
      end
      out_ch.ready <= ready_next;
      hold_active <= hold_left > 0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int produced;
    int n;
    int span;
    int base;
    int pick;
    logic end_on_term;
    logic full_row_done;
    logic late_pause_done;
    logic [COL_W-1:0] order[COLUMNS];
    logic [COL_W-1:0] swap;

    pause_pending = 1'b0;

    // Directed part: empty rows, ignored items, saturation both ways, order of first use.
    queue_term(6'd0, 32'h0, 32'h0, 1'b0, 1'b1);
    queue_term(6'h2a, 32'h5555_aaaa, 32'haaaa_5555, 1'b0, 1'b0);
    queue_term(6'd63, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b1);
    queue_term(6'd0, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
    queue_term(6'd0, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
    queue_term(6'd17, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0);
    queue_term(6'd5, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b0);
    queue_term(6'd5, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b0);
    queue_term(6'd5, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b0);
    queue_term(6'd17, 32'h1234_5678, 32'h7654_3210, 1'b0, 1'b0);
    queue_term(6'd0, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b0);
    queue_term(6'd17, 32'h0, 32'hdead_beef, 1'b1, 1'b0);
    queue_term(6'd0, 32'h0, 32'h0, 1'b0, 1'b1);
    queue_term(6'd1, 32'h0001_0000, 32'h0001_0000, 1'b1, 1'b1);
    queue_term(6'd0, 32'h0, 32'h0, 1'b0, 1'b1);
    queue_term(6'h3f, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 1'b1);
    queue_term(6'd42, 32'hffff_0000, 32'h0001_0000, 1'b1, 1'b0);
    queue_term(6'd42, 32'h0001_0000, 32'h0001_0000, 1'b1, 1'b1);

    // Random part: mostly well-formed rows, with stray items and bare row ends.
    produced = 0;
    full_row_done = 1'b0;
    late_pause_done = 1'b0;
    pause_pending = 1'b1;
    while (produced < RANDOM_ITEMS) begin
      if (!late_pause_done && produced >= 76) begin
        late_pause_done = 1'b1;
        pause_pending = 1'b1;
      end
      if (!full_row_done && produced >= 12) begin
        full_row_done = 1'b1;
        for (int c = 0; c < COLUMNS; c++) begin
          order[c] = COL_W'(c);
        end
        for (int c = COLUMNS - 1; c > 0; c--) begin
          pick = $urandom_range(0, c);
          swap = order[c];
          order[c] = order[pick];
          order[pick] = swap;
        end
        for (int c = 0; c < COLUMNS; c++) begin
          queue_term(order[c], random_factor(), random_factor(), 1'b1, c == COLUMNS - 1);
        end
        produced += COLUMNS;
      end else begin
        case ($urandom_range(0, 15))
          0: queue_noise();
          1: begin
            queue_bare_end();
            produced++;
          end
          default: begin
            n = $urandom_range(1, 8);
            span = $urandom_range(0, 9);
            base = $urandom_range(0, COLUMNS - 1 - span);
            end_on_term = 1'($urandom_range(0, 1));
            for (int i = 0; i < n; i++) begin
              if ($urandom_range(0, 9) == 0) begin
                queue_noise();
              end
              queue_term(6'(base + $urandom_range(0, span)), random_factor(), random_factor(),
                         1'b1, end_on_term && i == n - 1);
              produced++;
            end
            if (!end_on_term) begin
              queue_bare_end();
              produced++;
            end
          end
        endcase
      end
    end

    do begin
      @(posedge clk);
    end while (rst || term_queue.size() > 0 || offering || expected_entries.size() > 0);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/sra_pkg.sv
hw/rtl/sra_if.sv
hw/rtl/sparse_row_accumulator.sv
dv/sparse_row_accumulator_tb.sv
